[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg : shared types and constants of the text console writer
// screen geometry, character codes, state machine states and the command and
// status records that join the controller to the datapath
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int TAB_PITCH     = 4;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(CELL_COUNT);

    // field widths
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int OP_W    = 2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [ROW_W-1:0]  ROW_COUNT = ROW_W'(SCREEN_HEIGHT);
    localparam logic [COL_W-1:0]  COL_COUNT = COL_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LINE_LEN  = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELL_COUNT - SCREEN_WIDTH - 1);

    // cell contents and character codes
    localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CHAR_W-1:0]  BLANK_CHAR  = 8'h20;
    localparam logic [CHAR_W-1:0]  CHAR_NL     = 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_CR     = 8'd13;
    localparam logic [CHAR_W-1:0]  CHAR_BS     = 8'd8;
    localparam logic [CHAR_W-1:0]  CHAR_TAB    = 8'd9;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CH_PRINT,
        CH_NEWLINE,
        CH_RETURN,
        CH_BACKSPACE,
        CH_TAB
    } t_char_kind;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_TAB,
        S_BS_WRITE,
        S_CLEAR,
        S_READ_OUT,
        S_SCROLL_PRIME,
        S_SCROLL_COPY,
        S_SCROLL_BLANK
    } t_state;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_FILL_RESET,
        MEM_FILL_BLANK,
        MEM_CHAR_AT_CURSOR,
        MEM_BLANK_AT_CURSOR,
        MEM_COPY
    } t_mem_op;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_RETURN,
        CUR_BACK,
        CUR_SET,
        CUR_HOME
    } t_cur_op;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_CLEAR
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_ITEM,
        RD_SCROLL_CUR,
        RD_SCROLL_NEXT
    } t_rd_op;

    typedef struct packed {
        logic    load;
        t_mem_op mem_op;
        t_cur_op cur_op;
        t_idx_op idx_op;
        t_rd_op  rd_op;
        logic    finish;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode    op;
        t_char_kind kind;
        logic       col_last;
        logic       row_last;
        logic       tab_stop;
        logic       idx_last;
        logic       copy_last;
    } t_dp_status;

endpackage

[rtl/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath : screen store, cursor, walk counter and result registers
// carries out one command from the controller each cycle
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcw_pkg::t_dp_cmd             i_cmd,
    output tcw_pkg::t_dp_status          o_status,
    input  logic [tcw_pkg::COLOR_W-1:0]  i_text_color,
    input  logic [tcw_pkg::OP_W-1:0]     i_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]    i_row,
    input  logic [tcw_pkg::COL_W-1:0]    i_column,
    output logic                         o_valid,
    output logic [tcw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]    o_cursor_column,
    output logic [tcw_pkg::POS_W-1:0]    o_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]   o_read_cell
);
    import tcw_pkg::*;

    // item registers
    t_opcode           r_op;
    logic [CHAR_W-1:0] r_char;
    logic [ROW_W-1:0]  r_row_in;
    logic [COL_W-1:0]  r_col_in;

    // cursor and walk counter
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ADDR_W-1:0] r_idx, n_idx;

    // screen store
    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rd_data;

    // result registers
    logic              r_valid;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic [CELL_W-1:0] r_out_cell;

    logic              in_range;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] item_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [COL_W-1:0]  col_plus1;
    t_char_kind        kind;

    assign in_range  = (r_row_in < ROW_COUNT) && (r_col_in < COL_COUNT);
    assign cur_addr  = ADDR_W'(ADDR_W'(r_cur_row) * LINE_LEN) + ADDR_W'(r_cur_col);
    assign item_addr = ADDR_W'(ADDR_W'(r_row_in) * LINE_LEN) + ADDR_W'(r_col_in);
    assign col_plus1 = r_cur_col + COL_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_opcode'(i_opcode);
            r_char   <= i_char_code;
            r_row_in <= i_row;
            r_col_in <= i_column;
        end
    end

    // character class decode
    always_comb begin
        unique case (r_char)
            CHAR_NL:  kind = CH_NEWLINE;
            CHAR_CR:  kind = CH_RETURN;
            CHAR_BS:  kind = CH_BACKSPACE;
            CHAR_TAB: kind = CH_TAB;
            default:  kind = CH_PRINT;
        endcase
    end

    always_comb begin
        o_status.op        = r_op;
        o_status.kind      = kind;
        o_status.col_last  = (r_cur_col == LAST_COL);
        o_status.row_last  = (r_cur_row == LAST_ROW);
        o_status.tab_stop  = ((col_plus1 % COL_W'(TAB_PITCH)) == '0);
        o_status.idx_last  = (r_idx == LAST_CELL);
        o_status.copy_last = (r_idx == LAST_COPY);
    end

    // store write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = {i_text_color, BLANK_CHAR};
        case (i_cmd.mem_op)
            MEM_FILL_RESET: begin
                wr_en   = 1'b1;
                wr_data = RESET_CELL;
            end
            MEM_FILL_BLANK: begin
                wr_en   = 1'b1;
            end
            MEM_CHAR_AT_CURSOR: begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
                wr_data = {i_text_color, r_char};
            end
            MEM_BLANK_AT_CURSOR: begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
            end
            MEM_COPY: begin
                wr_en   = 1'b1;
                wr_data = r_rd_data;
            end
            default: begin
                wr_en   = 1'b0;
            end
        endcase
    end

    // store read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = item_addr;
        case (i_cmd.rd_op)
            RD_ITEM: begin
                rd_en   = in_range;
            end
            RD_SCROLL_CUR: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + LINE_LEN;
            end
            RD_SCROLL_NEXT: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + LINE_LEN + ADDR_W'(1);
            end
            default: begin
                rd_en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // cursor update
    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        case (i_cmd.cur_op)
            CUR_ADVANCE: begin
                n_cur_col = col_plus1;
            end
            CUR_NEWLINE: begin
                n_cur_col = '0;
                if (r_cur_row != LAST_ROW) begin
                    n_cur_row = r_cur_row + ROW_W'(1);
                end
            end
            CUR_RETURN: begin
                n_cur_col = '0;
            end
            CUR_BACK: begin
                if (r_cur_col != '0) begin
                    n_cur_col = r_cur_col - COL_W'(1);
                end else if (r_cur_row != '0) begin
                    n_cur_row = r_cur_row - ROW_W'(1);
                    n_cur_col = LAST_COL;
                end
            end
            CUR_SET: begin
                n_cur_row = (r_row_in < ROW_COUNT) ? r_row_in : LAST_ROW;
                n_cur_col = (r_col_in < COL_COUNT) ? r_col_in : LAST_COL;
            end
            CUR_HOME: begin
                n_cur_row = '0;
                n_cur_col = '0;
            end
            default: begin
                n_cur_row = r_cur_row;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_INC:   n_idx = r_idx + ADDR_W'(1);
            IDX_CLEAR: n_idx = '0;
            default:   n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_idx     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_idx     <= n_idx;
            r_valid   <= i_cmd.finish;
        end
    end

    assign n_out_pos = POS_W'(POS_W'(n_cur_row) * POS_W'(SCREEN_WIDTH)) + POS_W'(n_cur_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_row  <= n_cur_row;
            r_out_col  <= n_cur_col;
            r_out_pos  <= n_out_pos;
            r_out_cell <= ((r_op == OP_READ) && in_range) ? r_rd_data : '0;
        end
    end

    assign o_valid           = r_valid;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_column   = r_out_col;
    assign o_cursor_position = r_out_pos;
    assign o_read_cell       = r_out_cell;

endmodule

[rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl : sequencing state machine of the text console writer
// steps the datapath through character handling, store walks and reads
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd    o_cmd
);
    import tcw_pkg::*;

    t_state r_state, n_state;
    t_state tab_next;
    logic   tab_here;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // a tab's first step runs in the execute state, any further ones in its own state
    assign tab_here = (r_state == S_TAB) ||
                      ((r_state == S_EXEC) && (i_status.op == OP_PUT) &&
                       (i_status.kind == CH_TAB));

    always_comb begin
        if (i_status.col_last) begin
            tab_next = i_status.row_last ? S_SCROLL_PRIME : S_IDLE;
        end else begin
            tab_next = i_status.tab_stop ? S_IDLE : S_TAB;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_status.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_status.op)
                    OP_PUT: begin
                        case (i_status.kind)
                            CH_NEWLINE:   n_state = i_status.row_last ? S_SCROLL_PRIME
                                                                      : S_IDLE;
                            CH_RETURN:    n_state = S_IDLE;
                            CH_BACKSPACE: n_state = S_BS_WRITE;
                            CH_TAB:       n_state = tab_next;
                            default: begin
                                n_state = (i_status.col_last && i_status.row_last)
                                          ? S_SCROLL_PRIME : S_IDLE;
                            end
                        endcase
                    end
                    OP_CLEAR: n_state = S_CLEAR;
                    OP_SET:   n_state = S_IDLE;
                    OP_READ:  n_state = S_READ_OUT;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_TAB:          n_state = tab_next;
            S_BS_WRITE:     n_state = S_IDLE;
            S_CLEAR: begin
                if (i_status.idx_last) n_state = S_IDLE;
            end
            S_READ_OUT:     n_state = S_IDLE;
            S_SCROLL_PRIME: n_state = S_SCROLL_COPY;
            S_SCROLL_COPY: begin
                if (i_status.copy_last) n_state = S_SCROLL_BLANK;
            end
            S_SCROLL_BLANK: begin
                if (i_status.idx_last) n_state = S_IDLE;
            end
            default:        n_state = S_INIT;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.load   = 1'b0;
        o_cmd.mem_op = MEM_NONE;
        o_cmd.cur_op = CUR_HOLD;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.rd_op  = RD_NONE;
        o_cmd.finish = 1'b0;
        if (tab_here) begin
            o_cmd.mem_op = MEM_BLANK_AT_CURSOR;
            if (i_status.col_last) begin
                o_cmd.cur_op = CUR_NEWLINE;
                o_cmd.finish = !i_status.row_last;
            end else begin
                o_cmd.cur_op = CUR_ADVANCE;
                o_cmd.finish = i_status.tab_stop;
            end
        end else begin
            unique case (r_state) inside
                S_INIT: begin
                    o_cmd.mem_op = MEM_FILL_RESET;
                    o_cmd.idx_op = i_status.idx_last ? IDX_CLEAR : IDX_INC;
                end
                S_IDLE: begin
                    o_cmd.load = i_start;
                end
                S_EXEC: begin
                    unique case (i_status.op)
                        OP_PUT: begin
                            case (i_status.kind)
                                CH_NEWLINE: begin
                                    o_cmd.cur_op = CUR_NEWLINE;
                                    o_cmd.finish = !i_status.row_last;
                                end
                                CH_RETURN: begin
                                    o_cmd.cur_op = CUR_RETURN;
                                    o_cmd.finish = 1'b1;
                                end
                                CH_BACKSPACE: begin
                                    o_cmd.cur_op = CUR_BACK;
                                end
                                default: begin
                                    o_cmd.mem_op = MEM_CHAR_AT_CURSOR;
                                    o_cmd.cur_op = i_status.col_last ? CUR_NEWLINE
                                                                     : CUR_ADVANCE;
                                    o_cmd.finish = !(i_status.col_last &&
                                                     i_status.row_last);
                                end
                            endcase
                        end
                        OP_SET: begin
                            o_cmd.cur_op = CUR_SET;
                            o_cmd.finish = 1'b1;
                        end
                        OP_READ: begin
                            o_cmd.rd_op = RD_ITEM;
                        end
                        default: begin
                            o_cmd.load = 1'b0;
                        end
                    endcase
                end
                S_BS_WRITE: begin
                    o_cmd.mem_op = MEM_BLANK_AT_CURSOR;
                    o_cmd.finish = 1'b1;
                end
                S_CLEAR, S_SCROLL_BLANK: begin
                    o_cmd.mem_op = MEM_FILL_BLANK;
                    if (i_status.idx_last) begin
                        o_cmd.idx_op = IDX_CLEAR;
                        o_cmd.cur_op = (r_state == S_CLEAR) ? CUR_HOME : CUR_HOLD;
                        o_cmd.finish = 1'b1;
                    end else begin
                        o_cmd.idx_op = IDX_INC;
                    end
                end
                S_READ_OUT: begin
                    o_cmd.finish = 1'b1;
                end
                S_SCROLL_PRIME: begin
                    o_cmd.rd_op = RD_SCROLL_CUR;
                end
                S_SCROLL_COPY: begin
                    o_cmd.mem_op = MEM_COPY;
                    o_cmd.idx_op = IDX_INC;
                    o_cmd.rd_op  = i_status.copy_last ? RD_NONE : RD_SCROLL_NEXT;
                end
                default: begin
                    o_cmd.load = 1'b0;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/text_console_character_writer.sv]
// ----------------------------------------------------------------------------
// text_console_character_writer : 80x25 text console engine
// owns a screen of 16-bit cells (character low byte, attribute high byte) and
// a cursor; puts characters, clears, sets the cursor and reads cells
//
//   channel   direction  handshake                      payload
//   command   in         start high while busy low      opcode, char_code, row, column
//   result    out        o_valid high for one cycle     cursor row/column/position, cell
//   config    in         psel & penable & pwrite        text_color at word 0
//
// a plain character, return or set cursor is done in the execute state; busy
// is low again in the result strobe cycle; backspace adds a blanking state,
// read a read-out state, a tab blanks a cell per step up to its tab stop;
// clear walks all 2000 cells, and a scroll copies one cell per cycle through
// the read and write ports, then blanks the last line; after reset a clearing
// pass fills the store with blanks while busy stays high; config writes are
// always taken; the result cannot be stalled: its strobe is high for one cycle
// ----------------------------------------------------------------------------
module text_console_character_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [tcw_pkg::OP_W-1:0]        i_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]       i_row,
    input  logic [tcw_pkg::COL_W-1:0]       i_column,
    // result channel
    output logic                            o_valid,
    output logic [tcw_pkg::ROW_W-1:0]       o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]       o_cursor_column,
    output logic [tcw_pkg::POS_W-1:0]       o_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]      o_read_cell,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import tcw_pkg::*;

    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [COLOR_W-1:0] r_text_color;
    logic               reg_hit;
    logic               cfg_write;

    // word address decode, byte offset bits ignored
    assign reg_hit   = (paddr[APB_ADDR_W-1] == REG_TEXT_COLOR);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
        end else if (cfg_write && reg_hit) begin
            r_text_color <= pwdata[COLOR_W-1:0];
        end
    end

    // register read back, zero beyond the list
    assign prdata = reg_hit ? APB_DATA_W'(r_text_color) : '0;

    // sequencer
    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // screen store, cursor and result registers
    tcw_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_text_color      (r_text_color),
        .i_opcode          (i_opcode),
        .i_char_code       (i_char_code),
        .i_row             (i_row),
        .i_column          (i_column),
        .o_valid           (o_valid),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_column   (o_cursor_column),
        .o_cursor_position (o_cursor_position),
        .o_read_cell       (o_read_cell)
    );

`ifndef SYNTH
    // the strobe comes only once the sequencer is back in idle
    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted item always occupies the sequencer for the next cycle
    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("sequencer did not take the item");

    // at most one result per item, so strobes never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back to back result strobes");

    // reported cursor lies on the screen and matches its linear position
    a_cursor_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_cursor_row < ROW_COUNT) && (o_cursor_column < COL_COUNT) &&
                     (o_cursor_position == POS_W'(POS_W'(o_cursor_row) *
                      POS_W'(SCREEN_WIDTH)) + POS_W'(o_cursor_column))))
        else $error("cursor result inconsistent");
`endif

endmodule
